>>> src/asa_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and constants of the acceptance step adjuster.
package asa_pkg;

    localparam int ITER_W     = 32;
    localparam int FRAC_W     = 17;
    localparam int FACTOR_W   = 17;
    localparam int LIMIT_W    = 32;
    localparam int WINDOW_W   = 16;
    localparam int STEP_OUT_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int Q_SHIFT    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP = 3'd4;

    localparam logic [FRAC_W-1:0]     TARGET_RST    = 17'd32768;
    localparam logic [FACTOR_W-1:0]   FACTOR_RST    = 17'd58982;
    localparam logic [LIMIT_W-1:0]    LIMIT_RST     = 32'd10000;
    localparam logic [WINDOW_W-1:0]   WINDOW_RST    = 16'd100;
    localparam logic [CFG_DATA_W-1:0] INIT_STEP_RST = 32'd65536;

    localparam logic ARITH_DIV = 1'b0;
    localparam logic ARITH_MUL = 1'b1;

    typedef struct packed {
        logic [ITER_W-1:0] iteration_number;
        logic              move_accepted;
    } t_in_beat;

    typedef struct packed {
        logic [STEP_OUT_W-1:0] step_size;
        logic                  window_closed;
        logic [FRAC_W-1:0]     acceptance_fraction;
        logic                  step_grew;
    } t_out_beat;

    typedef struct packed {
        logic capture;
        logic count;
        logic start_mod;
        logic start_frac;
        logic frac_store;
        logic adj_start;
        logic step_store;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_range;
        logic window_zero;
        logic rem_zero;
        logic factor_zero;
        logic arith_done;
    } t_dp_stat;

endpackage

>>> src/asa_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one trial beat into the adjuster.
interface asa_in_if import asa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/asa_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one result beat out of the adjuster.
interface asa_out_if import asa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/asa_arith.sv
`timescale 1ns / 1ps
// Shared iterative unit: restoring divider at two bits per cycle and shift-add multiplier.
module asa_arith import asa_pkg::*; #(
    parameter int DIV_W  = 48,
    parameter int DVSR_W = 17,
    parameter int STEP_W = 32,
    parameter int CNT_W  = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_op,
    input  logic [CNT_W-1:0]           i_cycles,
    input  logic [DIV_W-1:0]           i_dividend,
    input  logic [DVSR_W-1:0]          i_divisor,
    input  logic [STEP_W-1:0]          i_mcand,
    input  logic [FACTOR_W-1:0]        i_mplier,
    output logic                       o_done,
    output logic [DIV_W-1:0]           o_quo,
    output logic [DVSR_W-1:0]          o_rem,
    output logic [STEP_W+FACTOR_W-1:0] o_prod
);

    localparam int PROD_W = STEP_W + FACTOR_W;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic                r_op, n_op;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DIV_W-1:0]    r_quo, n_quo;
    logic [DVSR_W-1:0]   r_rem, n_rem;
    logic [DVSR_W-1:0]   r_div, n_div;
    logic [STEP_W-1:0]   r_mcand, n_mcand;
    logic [PROD_W-1:0]   r_prod, n_prod;

    logic [DVSR_W:0]     s1, s2;
    logic [DVSR_W-1:0]   rem1, rem2;
    logic                q1, q2;
    logic [STEP_W:0]     psum;

    always_comb begin
        s1   = {r_rem, r_quo[DIV_W-1]};
        q1   = s1 >= {1'b0, r_div};
        rem1 = q1 ? DVSR_W'(s1 - {1'b0, r_div}) : s1[DVSR_W-1:0];
        s2   = {rem1, r_quo[DIV_W-2]};
        q2   = s2 >= {1'b0, r_div};
        rem2 = q2 ? DVSR_W'(s2 - {1'b0, r_div}) : s2[DVSR_W-1:0];
        psum = {1'b0, r_prod[PROD_W-1:FACTOR_W]}
             + (r_prod[0] ? {1'b0, r_mcand} : {(STEP_W + 1){1'b0}});
    end

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_mcand = r_mcand;
        n_prod  = r_prod;
        if (i_start) begin
            n_busy  = 1'b1;
            n_op    = i_op;
            n_cnt   = i_cycles;
            n_quo   = i_dividend;
            n_rem   = '0;
            n_div   = i_divisor;
            n_mcand = i_mcand;
            n_prod  = {{STEP_W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            if (r_op == ARITH_DIV) begin
                n_quo = {r_quo[DIV_W-3:0], q1, q2};
                n_rem = rem2;
            end else begin
                n_prod = {psum, r_prod[FACTOR_W-1:1]};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op    <= n_op;
        r_cnt   <= n_cnt;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_mcand <= n_mcand;
        r_prod  <= n_prod;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_prod = r_prod;

endmodule

>>> src/asa_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration, counters, step and fraction state, shared arithmetic and result register.
module asa_dp import asa_pkg::*; #(
    parameter int COUNT_WIDTH = 16,
    parameter int STEP_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_beat              i_in_beat,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_stat              o_stat,
    output t_out_beat             o_out_beat
);

    localparam int N_MOD0  = ITER_W;
    localparam int N_MOD   = N_MOD0 + (N_MOD0 % 2);
    localparam int N_FRAC0 = COUNT_WIDTH + Q_SHIFT;
    localparam int N_FRAC  = N_FRAC0 + (N_FRAC0 % 2);
    localparam int N_GROW0 = STEP_WIDTH + Q_SHIFT;
    localparam int N_GROW  = N_GROW0 + (N_GROW0 % 2);
    localparam int DW1     = (N_FRAC > N_MOD) ? N_FRAC : N_MOD;
    localparam int DIV_W   = (N_GROW > DW1) ? N_GROW : DW1;
    localparam int DVSR_W  = (COUNT_WIDTH + 1 > FACTOR_W) ? COUNT_WIDTH + 1 : FACTOR_W;
    localparam int CYC_MAX = (DIV_W / 2 > FACTOR_W) ? DIV_W / 2 : FACTOR_W;
    localparam int CNT_W   = $clog2(CYC_MAX + 1);
    localparam int PROD_W  = STEP_WIDTH + FACTOR_W;
    localparam int SH_MOD  = DIV_W - N_MOD;
    localparam int SH_FRAC = DIV_W - N_FRAC;
    localparam int SH_GROW = DIV_W - N_GROW;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [STEP_WIDTH-1:0]  STEP_MAX  = {STEP_WIDTH{1'b1}};

    logic [FRAC_W-1:0]      r_target;
    logic [FACTOR_W-1:0]    r_factor;
    logic [LIMIT_W-1:0]     r_limit;
    logic [WINDOW_W-1:0]    r_window;
    logic [STEP_WIDTH-1:0]  r_step, n_step;
    logic [COUNT_WIDTH-1:0] r_acc_cnt, n_acc_cnt;
    logic [COUNT_WIDTH-1:0] r_rej_cnt, n_rej_cnt;
    logic [FRAC_W-1:0]      r_frac, n_frac;
    logic [ITER_W-1:0]      r_iter;
    logic                   r_acc;
    logic                   r_closed, n_closed;
    logic                   r_grow, n_grow;
    t_out_beat              r_out;

    logic [COUNT_WIDTH:0]   total;
    logic [FRAC_W-1:0]      quo_frac;
    logic                   arith_start;
    logic                   arith_op;
    logic [CNT_W-1:0]       arith_cycles;
    logic [DIV_W-1:0]       arith_dividend;
    logic [DVSR_W-1:0]      arith_divisor;
    logic                   arith_done;
    logic [DIV_W-1:0]       arith_quo;
    logic [DVSR_W-1:0]      arith_rem;
    logic [PROD_W-1:0]      arith_prod;
    logic [STEP_WIDTH-1:0]  grow_val;
    logic [STEP_WIDTH-1:0]  shrink_val;

    assign total    = {1'b0, r_acc_cnt} + {1'b0, r_rej_cnt};
    assign quo_frac = arith_quo[FRAC_W-1:0];

    always_comb begin
        arith_op       = ARITH_DIV;
        arith_cycles   = CNT_W'(N_MOD / 2);
        arith_dividend = DIV_W'(r_iter) << SH_MOD;
        arith_divisor  = DVSR_W'(r_window);
        if (i_cmd.start_frac) begin
            arith_cycles   = CNT_W'(N_FRAC / 2);
            arith_dividend = DIV_W'({r_acc_cnt, {Q_SHIFT{1'b0}}}) << SH_FRAC;
            arith_divisor  = DVSR_W'(total);
        end else if (i_cmd.adj_start && r_grow) begin
            arith_cycles   = CNT_W'(N_GROW / 2);
            arith_dividend = DIV_W'({r_step, {Q_SHIFT{1'b0}}}) << SH_GROW;
            arith_divisor  = DVSR_W'(r_factor);
        end else if (i_cmd.adj_start) begin
            arith_op     = ARITH_MUL;
            arith_cycles = CNT_W'(FACTOR_W);
        end
    end

    assign arith_start = i_cmd.start_mod | i_cmd.start_frac
                       | (i_cmd.adj_start & (r_factor != '0));

    asa_arith #(
        .DIV_W  (DIV_W),
        .DVSR_W (DVSR_W),
        .STEP_W (STEP_WIDTH),
        .CNT_W  (CNT_W)
    ) u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (arith_start),
        .i_op       (arith_op),
        .i_cycles   (arith_cycles),
        .i_dividend (arith_dividend),
        .i_divisor  (arith_divisor),
        .i_mcand    (r_step),
        .i_mplier   (r_factor),
        .o_done     (arith_done),
        .o_quo      (arith_quo),
        .o_rem      (arith_rem),
        .o_prod     (arith_prod)
    );

    assign grow_val   = (|arith_quo[DIV_W-1:STEP_WIDTH]) ? STEP_MAX
                                                         : arith_quo[STEP_WIDTH-1:0];
    assign shrink_val = arith_prod[PROD_W-1] ? STEP_MAX
                                             : arith_prod[PROD_W-2:Q_SHIFT];

    always_comb begin
        o_stat.in_range    = r_iter <= r_limit;
        o_stat.window_zero = r_window == '0;
        o_stat.rem_zero    = arith_rem == '0;
        o_stat.factor_zero = r_factor == '0;
        o_stat.arith_done  = arith_done;
    end

    always_comb begin
        n_step    = r_step;
        n_acc_cnt = r_acc_cnt;
        n_rej_cnt = r_rej_cnt;
        n_frac    = r_frac;
        n_closed  = r_closed;
        n_grow    = r_grow;
        if (i_cmd.capture) begin
            n_closed = 1'b0;
            n_grow   = 1'b0;
        end
        if (i_cmd.count) begin
            if (r_acc) begin
                n_acc_cnt = (r_acc_cnt == COUNT_MAX) ? COUNT_MAX : r_acc_cnt + 1'b1;
            end else begin
                n_rej_cnt = (r_rej_cnt == COUNT_MAX) ? COUNT_MAX : r_rej_cnt + 1'b1;
            end
        end
        if (i_cmd.frac_store) begin
            n_frac    = quo_frac;
            n_grow    = !(quo_frac < r_target);
            n_closed  = 1'b1;
            n_acc_cnt = '0;
            n_rej_cnt = '0;
        end
        if (i_cmd.adj_start && (r_factor == '0)) begin
            n_step = r_grow ? STEP_MAX : '0;
        end
        if (i_cmd.step_store) begin
            n_step = r_grow ? grow_val : shrink_val;
        end
        if (i_cfg_we && (i_cfg_index == CFG_INIT_STEP)) begin
            n_step = STEP_WIDTH'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_RST;
            r_factor    <= FACTOR_RST;
            r_limit     <= LIMIT_RST;
            r_window    <= WINDOW_RST;
            r_step      <= STEP_WIDTH'(INIT_STEP_RST);
            r_acc_cnt   <= '0;
            r_rej_cnt   <= '0;
            r_frac      <= '0;
            r_closed    <= 1'b0;
            r_grow      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TARGET:    r_target    <= FRAC_W'(i_cfg_data);
                    CFG_FACTOR:    r_factor    <= FACTOR_W'(i_cfg_data);
                    CFG_LIMIT:     r_limit     <= LIMIT_W'(i_cfg_data);
                    CFG_WINDOW:    r_window    <= WINDOW_W'(i_cfg_data);
                    default: ;
                endcase
            end
            r_step    <= n_step;
            r_acc_cnt <= n_acc_cnt;
            r_rej_cnt <= n_rej_cnt;
            r_frac    <= n_frac;
            r_closed  <= n_closed;
            r_grow    <= n_grow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_iter <= i_in_beat.iteration_number;
            r_acc  <= i_in_beat.move_accepted;
        end
        if (i_cmd.out_load) begin
            r_out.step_size           <= STEP_OUT_W'(r_step);
            r_out.window_closed       <= r_closed;
            r_out.acceptance_fraction <= r_frac;
            r_out.step_grew           <= r_grow;
        end
    end

    assign o_out_beat = r_out;

    a_closed_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_closed |-> r_acc_cnt == '0 && r_rej_cnt == '0)
        else $error("Counters not cleared after a closed window.");

    a_grew_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_grow |-> r_closed)
        else $error("Step grew without a closed window.");

    a_frac_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.frac_store |-> arith_quo[DIV_W-1:FRAC_W] == '0 && quo_frac <= 17'd65536)
        else $error("Acceptance fraction out of range.");

endmodule

>>> src/asa_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences counting, window test, fraction and step update.
module asa_ctrl import asa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_FRAC   = 3'd3;
    localparam logic [2:0] S_ADJ_GO = 3'd4;
    localparam logic [2:0] S_ADJ    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_FINISH;
                if (i_stat.in_range) begin
                    o_cmd.count = 1'b1;
                    if (!i_stat.window_zero) begin
                        o_cmd.start_mod = 1'b1;
                        n_state         = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (i_stat.arith_done) begin
                    if (i_stat.rem_zero) begin
                        o_cmd.start_frac = 1'b1;
                        n_state          = S_FRAC;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FRAC: begin
                if (i_stat.arith_done) begin
                    o_cmd.frac_store = 1'b1;
                    n_state          = S_ADJ_GO;
                end
            end
            S_ADJ_GO: begin
                o_cmd.adj_start = 1'b1;
                n_state         = i_stat.factor_zero ? S_FINISH : S_ADJ;
            end
            S_ADJ: begin
                if (i_stat.arith_done) begin
                    o_cmd.step_store = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.arith_done |-> r_state == S_MOD || r_state == S_FRAC || r_state == S_ADJ)
        else $error("Arithmetic result arrived outside a waiting state.");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == S_CHECK)
        else $error("Accepted beat did not start processing.");

endmodule

>>> src/acceptance_step_adjuster_core.sv
`timescale 1ns / 1ps
// Top level of the acceptance step adjuster: controller, datapath and channel wiring.
//
// One trial beat is processed at a time. A beat beyond the adjust limit or with a zero
// window goes from the check straight to the finish state; a beat inside the limit runs
// the iteration-modulo-window division in the shared divider, which retires two quotient
// bits per cycle. A beat that closes a window adds the fraction division and the step
// update: a division when the step grows, a multiplication when it shrinks (one factor
// bit per cycle), and with a zero factor the step is set straight to its maximum or to
// zero. A result beat waits in the finish state while the output register still holds a
// result that is not yet taken. A new beat is taken while the previous result still
// waits in the output register.
module acceptance_step_adjuster_core import asa_pkg::*; #(
    parameter int COUNT_WIDTH = 16,
    parameter int STEP_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    asa_in_if.sink                i_in,
    asa_out_if.source             o_out
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_beat;

    asa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    asa_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .STEP_WIDTH  (STEP_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_beat   (i_in.payload),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_beat  (out_beat)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_beat;

endmodule
